// ----- hdl/tcm_pkg.sv -----
// Shared types and constants for the trie command matcher.
`default_nettype none

package tcm_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CNT    = 7'b0000010,
    ST_ENTRY  = 7'b0000100,
    ST_LINK   = 7'b0001000,
    ST_REDUCE = 7'b0010000,
    ST_REMAIN = 7'b0100000,
    ST_RESULT = 7'b1000000
  } tcm_state_e;

  // Action codes carried on the input tuser bit.
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CHAR  = 1'b1;

  localparam logic [7:0] CHAR_UPPER_A    = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z    = 8'd90;
  localparam logic [7:0] CASE_OFFSET     = 8'd32;
  localparam logic [7:0] ENTRY_CHAR_MASK = 8'h7F;
  localparam int         TERM_BIT        = 7;

endpackage

`default_nettype wire

// ----- hdl/tcm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module tcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/trie_command_matcher.sv -----
// Trie command matcher: sequencer walking a byte-table trie one read per cycle.
// Sequence: a table write word has its result word valid right after the accepting edge;
// a character word reads the count byte, then entry and link bytes per entry scanned,
// then reduce and remain states if it steps to a child (link reduced modulo the table depth).
// Throughput: one table read per cycle through the single RAM read port; no new word
// is taken until the result word is out. Reset returns the node pointer to the root.
`default_nettype none

module trie_command_matcher #(
  parameter int TABLE_DEPTH = 256,
  parameter int LINK_BYTES  = 1
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input words
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // table_addr[7:0], table_byte[15:8], char_in[23:16]
  input  wire logic        s_axis_tuser_i,  // action
  // result words
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [7:0]  m_axis_tdata_o,  // command_index
  output      logic [1:0]  m_axis_tuser_o   // command_valid[0], still_matching[1]
);

  import tcm_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int LW  = 8 * LINK_BYTES;
  localparam int DW  = LW + 1;
  localparam int BCW = (LINK_BYTES > 1) ? $clog2(LINK_BYTES) : 1;
  localparam logic [AW-1:0]  LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [8:0]     DEPTH_9   = 9'(TABLE_DEPTH);
  localparam logic [DW-1:0]  DEPTH_D   = DW'(TABLE_DEPTH);
  localparam logic [LW-1:0]  RECIP     = LW'((2 ** LW) / TABLE_DEPTH);
  localparam logic [BCW-1:0] LAST_BYTE = BCW'(LINK_BYTES - 1);

  // table pointer steps with wrap at the table end
  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
    wrap_inc = (p == LAST_ADDR) ? '0 : p + AW'(1);
  endfunction

  tcm_state_e state_q, state_d;
  logic [AW-1:0]  node_q, node_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic [7:0]     ch_q, ch_d;
  logic [7:0]     entry_q, entry_d;
  logic [7:0]     rem_q, rem_d;      // entries left in the node
  logic [BCW-1:0] bcnt_q, bcnt_d;    // link byte index
  logic [LW-1:0]  link_q, link_d;
  logic [LW-1:0]  quot_q, quot_d;    // link / depth, low by at most one
  logic           res_cv_q, res_cv_d;
  logic [7:0]     res_idx_q, res_idx_d;
  logic           res_sm_q, res_sm_d;
  logic           m_valid_q, m_valid_d;
  logic [7:0]     m_data_q, m_data_d;
  logic [1:0]     m_user_q, m_user_d;

  logic           accept;
  logic           out_free;
  logic           ram_we;
  logic [AW-1:0]  ram_raddr;
  logic [7:0]     ram_rdata;
  logic [7:0]     in_addr, in_byte, in_char, char_fold;
  logic [LW-1:0]  link_full;
  logic           entry_hit;
  logic [2*LW-1:0] quot_prod;
  logic [DW-1:0]  rem_est;
  logic [DW-1:0]  rem_fix;

  assign in_addr = s_axis_tdata_i[7:0];
  assign in_byte = s_axis_tdata_i[15:8];
  assign in_char = s_axis_tdata_i[23:16];

  // ASCII upper case folds to lower case
  assign char_fold = (in_char >= CHAR_UPPER_A && in_char <= CHAR_UPPER_Z)
                     ? in_char + CASE_OFFSET : in_char;

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // writes past the table are dropped
  assign ram_we    = accept && (s_axis_tuser_i == ACT_WRITE) && ({1'b0, in_addr} < DEPTH_9);
  assign ram_raddr = (state_q == ST_IDLE) ? node_q : pos_q;

  assign link_full = LW'({link_q, ram_rdata});
  assign entry_hit = ((entry_q & ENTRY_CHAR_MASK) == ch_q);

  // link mod depth by reciprocal multiply: quotient estimate is exact or one
  // short, so the remainder estimate is below twice the depth
  assign quot_prod = (2*LW)'(link_q) * (2*LW)'(RECIP);
  assign rem_est   = DW'(link_q) - DW'(quot_q) * DEPTH_D;
  assign rem_fix   = (rem_est >= DEPTH_D) ? rem_est - DEPTH_D : rem_est;

  tcm_ram #(
    .WIDTH(8),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_addr[AW-1:0]),
    .wdata_i(in_byte),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    node_d    = node_q;
    pos_d     = pos_q;
    ch_d      = ch_q;
    entry_d   = entry_q;
    rem_d     = rem_q;
    bcnt_d    = bcnt_q;
    link_d    = link_q;
    quot_d    = quot_q;
    res_cv_d  = res_cv_q;
    res_idx_d = res_idx_q;
    res_sm_d  = res_sm_q;
    m_valid_d = m_valid_q && !m_axis_tready_i;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (s_axis_tuser_i == ACT_WRITE) begin
            m_valid_d = 1'b1;
            m_data_d  = '0;
            m_user_d  = '0;
          end else begin
            // count byte read is in flight at node_q
            ch_d    = char_fold;
            pos_d   = wrap_inc(node_q);
            state_d = ST_CNT;
          end
        end
      end
      ST_CNT: begin
        res_cv_d  = 1'b0;
        res_idx_d = '0;
        res_sm_d  = 1'b0;
        if (ram_rdata == '0) begin
          node_d  = '0;
          state_d = ST_RESULT;
        end else begin
          rem_d   = ram_rdata;
          pos_d   = wrap_inc(pos_q);
          state_d = ST_ENTRY;
        end
      end
      ST_ENTRY: begin
        entry_d = ram_rdata;
        bcnt_d  = '0;
        pos_d   = wrap_inc(pos_q);
        state_d = ST_LINK;
      end
      ST_LINK: begin
        link_d = link_full;
        if (bcnt_q != LAST_BYTE) begin
          bcnt_d = bcnt_q + BCW'(1);
          pos_d  = wrap_inc(pos_q);
        end else if (entry_hit) begin
          if (entry_q[TERM_BIT]) begin
            res_cv_d  = 1'b1;
            res_idx_d = ram_rdata;
            node_d    = '0;
            state_d   = ST_RESULT;
          end else begin
            state_d = ST_REDUCE;
          end
        end else if (rem_q == 8'd1) begin
          node_d  = '0;
          state_d = ST_RESULT;
        end else begin
          rem_d   = rem_q - 8'd1;
          pos_d   = wrap_inc(pos_q);
          state_d = ST_ENTRY;
        end
      end
      ST_REDUCE: begin
        quot_d  = quot_prod[2*LW-1:LW];
        state_d = ST_REMAIN;
      end
      ST_REMAIN: begin
        node_d   = rem_fix[AW-1:0];
        res_sm_d = 1'b1;
        state_d  = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_data_d  = res_idx_q;
          m_user_d  = {res_sm_q, res_cv_q};
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      node_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      node_q    <= node_d;
      m_valid_q <= m_valid_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    ch_q      <= ch_d;
    entry_q   <= entry_d;
    rem_q     <= rem_d;
    bcnt_q    <= bcnt_d;
    link_q    <= link_d;
    quot_q    <= quot_d;
    res_cv_q  <= res_cv_d;
    res_idx_q <= res_idx_d;
    res_sm_q  <= res_sm_d;
    m_data_q  <= m_data_d;
    m_user_q  <= m_user_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for the trie command matcher: table writes and command characters.
`timescale 1ns / 1ps

module testbench;
  import tcm_pkg::*;

  localparam int TBL_DEPTH  = 256;
  localparam int LINK_N     = 1;
  localparam int WORD_COUNT = 1150;
  // Which copy of the trie a lookup works on: the one that steers stimulus
  // or the one that predicts results for accepted words.
  localparam int SIDE_STIM  = 0;
  localparam int SIDE_CHECK = 1;

  typedef struct packed {
    logic       hold;    // wait until all results are back before sending
    logic       act;
    logic [7:0] addr;
    logic [7:0] data;
    logic [7:0] ch;
  } stim_word_t;

  typedef struct packed {
    logic       cmd_valid;
    logic [7:0] cmd_index;
    logic       to_child;
  } match_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid;
  logic [23:0] s_data;
  logic        s_user;
  logic        s_ready;
  logic        m_valid;
  logic        m_ready;
  logic [7:0]  m_data;
  logic [1:0]  m_user;

  logic [7:0]  trie_mem [0:1][0:TBL_DEPTH-1];
  logic [7:0]  node_ptr [0:1];
  stim_word_t  pending[$];
  match_t      expected_q[$];
  logic        hold_next;
  logic        quiet;
  int          quiet_cnt;
  int          send_gap;
  int          recv_stall;
  int          errors;
  int          n_writes, n_chars, n_cmds, n_steps, n_drops;

  always #5 clk_i = ~clk_i;

  trie_command_matcher #(
    .TABLE_DEPTH(TBL_DEPTH),
    .LINK_BYTES (LINK_N)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .s_axis_tuser_i (s_user),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tuser_o (m_user)
  );

  // One step of the matcher on the chosen copy of the trie; updates that
  // copy's table and node pointer and returns the result word.
  function automatic match_t trie_step(input int side, input logic act,
                                       input logic [7:0] addr, input logic [7:0] data,
                                       input logic [7:0] ch);
    match_t      res;
    logic [7:0]  c;
    logic [7:0]  ent;
    logic [15:0] lnk;
    int          pos;
    int          cnt;
    res = '0;
    if (act == ACT_WRITE) begin
      if (addr < TBL_DEPTH) trie_mem[side][addr] = data;
      return res;
    end
    c = ch;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) c = c + CASE_OFFSET;
    pos = node_ptr[side];
    cnt = trie_mem[side][pos % TBL_DEPTH];
    pos++;
    for (int k = 0; k < cnt; k++) begin
      ent = trie_mem[side][pos % TBL_DEPTH];
      pos++;
      lnk = '0;
      for (int b = 0; b < LINK_N; b++) begin
        lnk = (lnk << 8) | trie_mem[side][pos % TBL_DEPTH];
        pos++;
      end
      if ((ent & ENTRY_CHAR_MASK) == c) begin
        if (ent[TERM_BIT]) begin
          // terminal entry: the link is the command number
          res.cmd_valid = 1'b1;
          res.cmd_index = lnk[7:0];
          node_ptr[side] = '0;
        end else begin
          res.to_child = 1'b1;
          node_ptr[side] = 8'(lnk % TBL_DEPTH);
        end
        return res;
      end
    end
    node_ptr[side] = '0;  // no entry matched: character dropped
    return res;
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic push_word(input logic act, input logic [7:0] addr, input logic [7:0] data,
                           input logic [7:0] ch);
    stim_word_t w;
    match_t     unused;
    w = '{hold: hold_next, act: act, addr: addr, data: data, ch: ch};
    hold_next = 1'b0;
    pending.push_back(w);
    unused = trie_step(SIDE_STIM, act, addr, data, ch);
  endtask

  task automatic push_write(input logic [7:0] addr, input logic [7:0] data);
    push_word(ACT_WRITE, addr, data, 8'($urandom));
  endtask

  task automatic push_char(input logic [7:0] ch);
    push_word(ACT_CHAR, 8'($urandom), 8'($urandom), ch);
  endtask

  // Spells of no idling at all on either side.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet     <= 1'b0;
      quiet_cnt <= 200;
    end else if (quiet_cnt == 0) begin
      quiet     <= ($urandom_range(0, 3) == 0);
      quiet_cnt <= $urandom_range(100, 400);
    end else begin
      quiet_cnt <= quiet_cnt - 1;
    end
  end

  // Word driver: sends queued words, inserts gaps, honors hold marks.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid  <= 1'b0;
      s_data   <= '0;
      s_user   <= ACT_WRITE;
      send_gap <= 0;
    end else if (!s_valid || s_ready) begin
      if (send_gap != 0) begin
        s_valid  <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending.size() == 0 ||
                   (pending[0].hold && (s_valid || expected_q.size() != 0))) begin
        s_valid <= 1'b0;
      end else begin : load_word
        stim_word_t w;
        w = pending.pop_front();
        s_valid  <= 1'b1;
        s_data   <= {w.ch, w.data, w.addr};
        s_user   <= w.act;
        send_gap <= (quiet || $urandom_range(0, 99) >= 35) ? 0 : pick_gap();
      end
    end
  end

  // Result side back-pressure.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready    <= 1'b0;
      recv_stall <= 0;
    end else if (recv_stall != 0) begin
      m_ready    <= 1'b0;
      recv_stall <= recv_stall - 1;
    end else begin
      m_ready <= 1'b1;
      if (!quiet && $urandom_range(0, 3) == 0) recv_stall <= pick_gap();
    end
  end

  // Predict on every accepted input word; check every accepted result word.
  always @(posedge clk_i) begin : result_check
    match_t want;
    match_t got;
    if (rst_ni) begin
      if (s_valid && s_ready) begin
        expected_q.push_back(trie_step(SIDE_CHECK, s_user, s_data[7:0], s_data[15:8],
                                       s_data[23:16]));
        if (s_user == ACT_WRITE) n_writes++;
        else n_chars++;
      end
      if (m_valid && m_ready) begin
        got = '{cmd_valid: m_user[0], cmd_index: m_data, to_child: m_user[1]};
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result word valid=%0d index=%02h step=%0d",
                   $time, got.cmd_valid, got.cmd_index, got.to_child);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            errors++;
            $display("%0t: exp valid=%0d idx=%02h step=%0d got valid=%0d idx=%02h step=%0d",
                     $time, want.cmd_valid, want.cmd_index, want.to_child,
                     got.cmd_valid, got.cmd_index, got.to_child);
          end
          if (want.cmd_valid) n_cmds++;
          else if (want.to_child) n_steps++;
          else if (want != '0 || n_chars > 0) n_drops++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    logic [7:0] nodes [0:5];
    int         n_nodes;
    int         cnt;
    int         k;
    int         pos;
    logic [7:0] ch;
    logic [7:0] ent;
    errors = 0;
    n_writes = 0;
    n_chars = 0;
    n_cmds = 0;
    n_steps = 0;
    n_drops = 0;
    hold_next = 1'b0;
    node_ptr[SIDE_STIM] = '0;
    node_ptr[SIDE_CHECK] = '0;

    // Fill the whole table first so no walk ever reads a byte never written.
    // Mostly small values: a stray pointer then lands on a short node.
    for (int a = 0; a < TBL_DEPTH; a++)
      push_write(a[7:0], ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 5)));

    // Directed trie. Root: 'a' ends command 0, 'b' steps to node 7, a later
    // terminal 'b' that the first match must shadow.
    hold_next = 1'b1;
    push_write(8'd0, 8'd3);
    push_write(8'd1, 8'hE1);
    push_write(8'd2, 8'h00);
    push_write(8'd3, 8'h62);
    push_write(8'd4, 8'd7);
    push_write(8'd5, 8'hE2);
    push_write(8'd6, 8'hFF);
    // Node 7: DEL ends command AB, char zero steps back to root, 'c' steps to
    // an empty node at 15.
    push_write(8'd7, 8'd3);
    push_write(8'd8, 8'hFF);
    push_write(8'd9, 8'hAB);
    push_write(8'd10, 8'h00);
    push_write(8'd11, 8'h00);
    push_write(8'd12, 8'h63);
    push_write(8'd13, 8'd15);
    push_write(8'd15, 8'h00);
    push_char("A");     // upper case folds, terminal with command 0
    push_char("b");     // first of two matching entries wins
    push_char(8'h7F);   // terminal at top of the 7-bit range
    push_char("B");
    push_char(8'h00);   // inner entry pointing back at the root
    push_char("b");
    push_char("c");
    push_char("x");     // empty node: nothing matches
    push_char(8'hE1);   // top bit set never matches
    push_char("@");     // just below the upper case range
    push_char("[");     // just above it

    // Random phases: build a small random trie, then walk it, with noise.
    while (pending.size() + n_writes + n_chars < WORD_COUNT) begin
      n_nodes = $urandom_range(2, 5);
      nodes[0] = 8'd0;
      for (int i = 1; i <= n_nodes; i++)
        nodes[i] = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(250, 255)) : 8'($urandom);
      hold_next = ($urandom_range(0, 2) == 0);
      for (int i = 0; i <= n_nodes; i++) begin
        cnt = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
        pos = nodes[i];
        push_write(pos[7:0], cnt[7:0]);
        for (int e = 0; e < cnt; e++) begin
          ent = ($urandom_range(0, 3) != 0) ? 8'("a" + $urandom_range(0, 5))
                                            : 8'($urandom_range(0, 127));
          if ($urandom_range(0, 99) < 35) begin
            push_write(8'(pos + 1 + 2 * e), ent | 8'h80);
            push_write(8'(pos + 2 + 2 * e), 8'($urandom));
          end else begin
            push_write(8'(pos + 1 + 2 * e), ent);
            push_write(8'(pos + 2 + 2 * e), nodes[$urandom_range(0, n_nodes)]);
          end
        end
      end
      repeat ($urandom_range(10, 30)) begin
        if ($urandom_range(0, 99) < 8) begin
          push_write(8'($urandom), 8'($urandom));  // noise that may break the trie
        end else begin
          cnt = trie_mem[SIDE_STIM][node_ptr[SIDE_STIM]];
          if (cnt != 0 && $urandom_range(0, 99) < 80) begin
            k  = $urandom_range(0, (cnt > 6) ? 6 : cnt - 1);
            ch = trie_mem[SIDE_STIM][8'(node_ptr[SIDE_STIM] + 1 + 2 * k)] & ENTRY_CHAR_MASK;
            if (ch >= "a" && ch <= "z" && $urandom_range(0, 2) == 0) ch = ch - CASE_OFFSET;
          end else if ($urandom_range(0, 1) == 0) begin
            ch = 8'($urandom);
          end else begin
            ch = 8'("a" + $urandom_range(0, 5)) - (($urandom_range(0, 1) == 0) ? 8'd0 : CASE_OFFSET);
          end
          push_char(ch);
        end
      end
    end

    while (rst_ni == 1'b0 || pending.size() != 0 || s_valid || expected_q.size() != 0)
      @(posedge clk_i);
    // Let any stray word from the block show up.
    repeat (600) @(posedge clk_i);
    if (expected_q.size() != 0) errors++;
    $display("Run covered %0d table writes and %0d characters:", n_writes, n_chars);
    $display("  %0d commands recognized, %0d child steps, rest dropped or writes.",
             n_cmds, n_steps);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    #40ms;
    $display("Mismatches found");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tcm_pkg.sv
hdl/tcm_ram.sv
hdl/trie_command_matcher.sv
bench/testbench.sv
